// ===== rtl/scs_pkg.sv =====
// shared types and constants for the sensor calibrate and smooth unit
package scs_pkg;

	// register map, index = paddr[4:3]
	localparam int unsigned APB_ADDR_W = 5;
	localparam logic [1:0] REG_KNOWN_A = 2'd0;
	localparam logic [1:0] REG_KNOWN_B = 2'd1;
	localparam logic [1:0] REG_CAL_A   = 2'd2;
	localparam logic [1:0] REG_CAL_B   = 2'd3;

	localparam logic [63:0] CAL_RESET = 64'h0000_0640_0000_0640;

	// shared divider: dividend magnitude and divisor magnitude widths
	localparam int unsigned DIV_W  = 33;
	localparam int unsigned DVSR_W = 17;

	localparam int unsigned AVG_W     = 24;
	localparam int unsigned AVG_SUM_W = 28;
	localparam logic [AVG_SUM_W-1:0] ROUND_BIAS = AVG_SUM_W'(5);

	// divide by ten as (x * ceil(2^31 / 10)) >> 31, exact for x below 2^30
	localparam int unsigned RECIP_SHIFT = 31;
	localparam logic [AVG_SUM_W-1:0] RECIP_TEN = AVG_SUM_W'(214748365);

	localparam logic signed [34:0] S16_MAX = 35'sd32767;
	localparam logic signed [34:0] S16_MIN = -35'sd32768;

	typedef struct packed {
		logic              channel;
		logic              connected;
		logic [63:0]       device_address;
		logic signed [11:0] raw_temp;
	} sample_word_t;

	typedef struct packed {
		logic              out_channel;
		logic              reading_valid;
		logic signed [23:0] smoothed_temp;
	} result_word_t;

	typedef struct packed {
		logic [63:0] known_address_a;
		logic [63:0] known_address_b;
		logic [63:0] calibration_a;
		logic [63:0] calibration_b;
	} cfg_regs_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CDIV,
		ST_CDIV_WAIT,
		ST_CAL_FIX,
		ST_AVG,
		ST_ADIV,
		ST_ASCALE,
		ST_WRITE
	} scs_state_t;

endpackage

// ===== rtl/scs_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module scs_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  scs_pkg::div_req_t req,
	output scs_pkg::div_rsp_t rsp
);
	import scs_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]  dividend_q;
	logic [DVSR_W-1:0] divisor_q;
	logic [DVSR_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVSR_W:0]   shifted;
	logic [DVSR_W:0]   diff;
	logic              fits;

	assign shifted = {rem_q, dividend_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign fits    = (shifted >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			rem_q      <= '0;
		end else if (busy_q) begin
			// quotient bits shift in behind the dividend
			rem_q      <= fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
			dividend_q <= {dividend_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dividend_q;

endmodule

// ===== rtl/scs_regs.sv =====
// apb configuration registers: known addresses and calibration entries
module scs_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [scs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [63:0]                       pwdata,
	output logic [63:0]                       prdata,
	output scs_pkg::cfg_regs_t                cfg
);
	import scs_pkg::*;

	cfg_regs_t  cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign idx   = paddr[4:3];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.known_address_a <= '0;
			cfg_q.known_address_b <= '0;
			cfg_q.calibration_a   <= CAL_RESET;
			cfg_q.calibration_b   <= CAL_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_KNOWN_A: cfg_q.known_address_a <= pwdata;
				REG_KNOWN_B: cfg_q.known_address_b <= pwdata;
				REG_CAL_A:   cfg_q.calibration_a   <= pwdata;
				REG_CAL_B:   cfg_q.calibration_b   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KNOWN_A: prdata = cfg_q.known_address_a;
			REG_KNOWN_B: prdata = cfg_q.known_address_b;
			REG_CAL_A:   prdata = cfg_q.calibration_a;
			REG_CAL_B:   prdata = cfg_q.calibration_b;
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sensor_calibrate_and_smooth_unit.sv =====
// top level: sequencer, channel state and output register of the calibrate and smooth unit
//
// usage
// - sample channel: sample_valid / sample_stall / sample. a word is taken when valid is high
//   and stall is low. stall stays high from the cycle after a word is taken until its
//   result has been moved into the output register
// - result channel: result_valid / result_stall / result, one result word per sample word,
//   in order. the result sits in an output register and holds while result_stall is high;
//   the unit then waits with its finished word and takes no new sample
// - apb port: 64-bit registers at byte addresses 0, 8, 16, 24; pready is always high.
//   write only while the unit is idle
// - datapath: one restoring divider does the calibration quotient; the divide by ten of
//   the running average is a reciprocal multiply, registered in ST_ADIV and then ST_ASCALE.
//   the next sample is taken in the cycle after the result is loaded
// - reset: channel valid flags and averages clear, calibration entries return to the
//   identity map, known addresses to zero, output register empties
module sensor_calibrate_and_smooth_unit #(
	parameter int CHANNELS      = 2,
	parameter int KNOWN_DEVICES = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample channel
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  scs_pkg::sample_word_t          sample,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output scs_pkg::result_word_t          result,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [scs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [63:0]                    pwdata,
	output logic [63:0]                    prdata,
	output logic                           pready
);
	import scs_pkg::*;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_regs_t  cfg;
	div_req_t   div_req;
	div_rsp_t   div_rsp;
	scs_state_t state_q, state_d;

	// latched sample
	logic               ch_q;
	logic               conn_q;
	logic               match_q;
	logic signed [11:0] raw_q;
	logic [63:0]        cal_q;

	// working registers
	logic signed [33:0]          prod_q;
	logic                        neg_q;
	logic signed [33:0]          qs_q;
	logic signed [15:0]          t_q;
	logic signed [AVG_SUM_W-1:0] sum_q;
	logic [2*AVG_SUM_W-1:0]      scale_q;
	logic signed [AVG_W-1:0]     new_avg_q;

	// per-channel state
	logic                    valid_q [CHANNELS];
	logic signed [AVG_W-1:0] avg_q   [CHANNELS];

	// output register
	logic         out_valid_q;
	result_word_t out_q;

	// control from the sequencer
	logic load_out;
	logic take;

	// derived values
	logic [CH_IDX_W-1:0]         ch_idx;
	logic                        in_range;
	logic                        cur_valid;
	logic signed [AVG_W-1:0]     cur_avg;
	logic signed [15:0]          ref_lo, ref_hi, raw_lo, raw_hi;
	logic signed [16:0]          raw_rng, ref_rng, diff;
	logic                        hit_a, hit_b;
	logic signed [34:0]          t_sum;
	logic signed [AVG_SUM_W-1:0] old_ext, fresh_ext;
	logic [AVG_SUM_W-1:0]        sum_mag;

	scs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	scs_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pready = 1'b1;

	// address match on the incoming word, lowest entry first
	assign hit_a = (sample.device_address == cfg.known_address_a);
	assign hit_b = (KNOWN_DEVICES >= 2) && (sample.device_address == cfg.known_address_b);

	assign ch_idx   = CH_IDX_W'(ch_q);
	assign in_range = (CHANNELS > 1) || (ch_q == 1'b0);
	assign cur_valid = in_range && valid_q[ch_idx];
	assign cur_avg   = avg_q[ch_idx];

	// calibration entry fields, msb first
	assign ref_lo  = cal_q[63:48];
	assign ref_hi  = cal_q[47:32];
	assign raw_lo  = cal_q[31:16];
	assign raw_hi  = cal_q[15:0];
	assign raw_rng = {raw_hi[15], raw_hi} - {raw_lo[15], raw_lo};
	assign ref_rng = {ref_hi[15], ref_hi} - {ref_lo[15], ref_lo};
	assign diff    = {{5{raw_q[11]}}, raw_q} - {raw_lo[15], raw_lo};

	assign t_sum = {qs_q[33], qs_q} + {{19{ref_lo[15]}}, ref_lo};

	// 9*old + 16*new
	assign old_ext   = {{(AVG_SUM_W-AVG_W){cur_avg[AVG_W-1]}}, cur_avg};
	assign fresh_ext = {{(AVG_SUM_W-20){t_q[15]}}, t_q, 4'b0000};

	// |sum| + 5 in one adder: a negative sum gives ~sum + 6
	assign sum_mag = sum_q[AVG_SUM_W-1] ? (~sum_q + ROUND_BIAS + AVG_SUM_W'(1))
	                                    : (sum_q + ROUND_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, divider requests and handshake
	always_comb begin
		state_d          = state_q;
		sample_stall     = (state_q != ST_IDLE);
		take             = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					take    = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!in_range || !conn_q) begin
					state_d = ST_WRITE;
				end else if (!match_q || (raw_rng == '0)) begin
					state_d = ST_AVG;
				end else begin
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q[33] ? DIV_W'(-prod_q) : DIV_W'(prod_q);
				div_req.divisor  = raw_rng[16] ? DVSR_W'(-raw_rng) : DVSR_W'(raw_rng);
				state_d          = ST_CDIV_WAIT;
			end
			ST_CDIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_CAL_FIX;
				end
			end
			ST_CAL_FIX: begin
				state_d = ST_AVG;
			end
			ST_AVG: begin
				state_d = cur_valid ? ST_ADIV : ST_WRITE;
			end
			ST_ADIV: begin
				state_d = ST_ASCALE;
			end
			ST_ASCALE: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			ch_q    <= sample.channel;
			conn_q  <= sample.connected;
			raw_q   <= sample.raw_temp;
			match_q <= hit_a || hit_b;
			cal_q   <= hit_a ? cfg.calibration_a : cfg.calibration_b;
		end
		case (state_q)
			ST_CHECK: begin
				// product is registered before it reaches the divider
				prod_q <= 34'(diff * ref_rng);
				t_q    <= {{4{raw_q[11]}}, raw_q};
			end
			ST_CDIV: begin
				neg_q <= prod_q[33] ^ raw_rng[16];
			end
			ST_CDIV_WAIT: begin
				if (div_rsp.done) begin
					qs_q <= neg_q ? -$signed({1'b0, div_rsp.quotient})
					              : $signed({1'b0, div_rsp.quotient});
				end
			end
			ST_CAL_FIX: begin
				if (t_sum > S16_MAX) begin
					t_q <= 16'sh7fff;
				end else if (t_sum < S16_MIN) begin
					t_q <= 16'sh8000;
				end else begin
					t_q <= t_sum[15:0];
				end
			end
			ST_AVG: begin
				sum_q     <= (old_ext <<< 3) + old_ext + fresh_ext;
				new_avg_q <= fresh_ext[AVG_W-1:0];
			end
			ST_ADIV: begin
				// (|sum| + 5) / 10 by reciprocal multiply
				neg_q   <= sum_q[AVG_SUM_W-1];
				scale_q <= sum_mag * RECIP_TEN;
			end
			ST_ASCALE: begin
				new_avg_q <= neg_q ? -$signed(scale_q[RECIP_SHIFT +: AVG_W])
				                   : $signed(scale_q[RECIP_SHIFT +: AVG_W]);
			end
			default: ;
		endcase
		if (load_out) begin
			out_q.out_channel   <= ch_q;
			out_q.reading_valid <= in_range && conn_q;
			out_q.smoothed_temp <= (in_range && conn_q) ? new_avg_q : '0;
		end
	end

	// channel state, written when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				valid_q[i] <= 1'b0;
				avg_q[i]   <= '0;
			end
		end else if (load_out && in_range) begin
			valid_q[ch_idx] <= conn_q;
			if (conn_q) begin
				avg_q[ch_idx] <= new_avg_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== test/sensor_calibrate_and_smooth_unit_test.sv =====
// testbench for the sensor calibrate and smooth unit: directed rows, then random phases
`timescale 1ns / 100ps

module sensor_calibrate_and_smooth_unit_test;
	import scs_pkg::*;

	// directed rows are either a register write or a sample word
	typedef enum logic {ROW_WRITE, ROW_READING} row_kind_t;

	// data holds the register value for a write and the device address for a reading;
	// reg_index only matters for writes. typed rows carry a result read off by hand
	typedef struct packed {
		row_kind_t          kind;
		logic [1:0]         reg_index;
		logic [63:0]        data;
		logic               channel;
		logic               connected;
		logic signed [11:0] raw;
		logic               typed;
		logic               want_valid;
		logic signed [23:0] want_temp;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 28;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_WORDS   = 100;

	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] SAT_CAL  = 64'h8000_7fff_0000_0001;
	localparam logic [63:0] INV_CAL  = 64'h7fff_8000_0000_0001;

	// clock, reset and block inputs, all known from time zero
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         sample_valid = 1'b0;
	logic         sample_stall;
	sample_word_t sample = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_word_t result;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;

	// our copy of the registers and the per-channel smoothing state
	logic [63:0] cfg_known_a = 64'd0;
	logic [63:0] cfg_known_b = 64'd0;
	logic [63:0] cfg_cal_a = CAL_RESET;
	logic [63:0] cfg_cal_b = CAL_RESET;
	bit          avg_valid [2] = '{1'b0, 1'b0};
	longint      avg_value [2] = '{64'sd0, 64'sd0};

	// smoothed results still owed by the block, oldest first
	result_word_t readings_due [$];

	// set for phases in which neither side idles
	bit steady_flow = 1'b0;

	int mismatches = 0;
	int sent_count = 0;
	int checked_count = 0;
	int write_count = 0;
	int n_calibrated = 0;
	int n_saturated = 0;
	int n_zero_range = 0;
	int n_disconnected = 0;

	// walked in order; writes wait for the block to drain first
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// reset settings: address zero matches entry a, identity map
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b0, 1'b1, 12'sd100, 1'b1, 1'b1, 24'sd1600},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b0, 1'b1, 12'sd200, 1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b0, 1'b0, 12'sd0, 1'b1, 1'b0, 24'sd0},
		// no address match, most negative raw value seeds a fresh average
		'{ROW_READING, REG_KNOWN_A, 64'hdead_beef_0bad_f00d, 1'b0, 1'b1, -12'sd2048,
			1'b1, 1'b1, -24'sd32768},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b1, 1'b1, 12'sd2047, 1'b1, 1'b1, 24'sd32752},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b1, 1'b1, -12'sd2048, 1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, 64'h5, 1'b1, 1'b1, -12'sd1, 1'b0, 1'b0, 24'sd0},
		// disconnect, then disconnect an already invalid channel
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b1, 1'b0, 12'sd0, 1'b1, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b1, 1'b0, 12'sd77, 1'b1, 1'b0, 24'sd0},
		// extreme addresses, a saturating entry and a zero raw range entry
		'{ROW_WRITE, REG_KNOWN_A, ALL_ONES, 1'b0, 1'b0, 12'sd0, 1'b0, 1'b0, 24'sd0},
		'{ROW_WRITE, REG_KNOWN_B, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 12'sd0,
			1'b0, 1'b0, 24'sd0},
		'{ROW_WRITE, REG_CAL_A, SAT_CAL, 1'b0, 1'b0, 12'sd0, 1'b0, 1'b0, 24'sd0},
		'{ROW_WRITE, REG_CAL_B, 64'h0000_0640_012c_012c, 1'b0, 1'b0, 12'sd0,
			1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, ALL_ONES, 1'b0, 1'b0, 12'sd0, 1'b1, 1'b0, 24'sd0},
		// saturates high, then low
		'{ROW_READING, REG_KNOWN_A, ALL_ONES, 1'b0, 1'b1, 12'sd2, 1'b1, 1'b1, 24'sd524272},
		'{ROW_READING, REG_KNOWN_A, ALL_ONES, 1'b0, 1'b1, -12'sd1, 1'b0, 1'b0, 24'sd0},
		// zero raw range passes the raw value through
		'{ROW_READING, REG_KNOWN_A, 64'h0123_4567_89ab_cdef, 1'b1, 1'b1, 12'sd1234,
			1'b1, 1'b1, 24'sd19744},
		'{ROW_READING, REG_KNOWN_A, 64'h0123_4567_89ab_cdef, 1'b1, 1'b1, -12'sd880,
			1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b0, 1'b1, 12'sh555, 1'b0, 1'b0, 24'sd0},
		// one bit away from a known address
		'{ROW_READING, REG_KNOWN_A, 64'hffff_ffff_ffff_fffe, 1'b0, 1'b1, 12'sd1,
			1'b0, 1'b0, 24'sd0},
		// both addresses equal: entry a has priority
		'{ROW_WRITE, REG_KNOWN_B, ALL_ONES, 1'b0, 1'b0, 12'sd0, 1'b0, 1'b0, 24'sd0},
		'{ROW_WRITE, REG_CAL_B, 64'h00a0_06e0_0000_0640, 1'b0, 1'b0, 12'sd0,
			1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, ALL_ONES, 1'b1, 1'b1, 12'sd1, 1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, ALL_ONES, 1'b1, 1'b0, 12'sd0, 1'b1, 1'b0, 24'sd0},
		// entry b alone now matches: offset of ten degrees
		'{ROW_WRITE, REG_KNOWN_A, 64'h0, 1'b0, 1'b0, 12'sd0, 1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, ALL_ONES, 1'b1, 1'b1, 12'sd0, 1'b1, 1'b1, 24'sd2560},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b0, 1'b1, 12'sd2047, 1'b0, 1'b0, 24'sd0},
		'{ROW_READING, REG_KNOWN_A, 64'h0, 1'b0, 1'b1, 12'sd0, 1'b0, 1'b0, 24'sd0}
	};

	sensor_calibrate_and_smooth_unit #(
		.CHANNELS(2),
		.KNOWN_DEVICES(2)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// works out the result word for one sample word and advances the channel state
	function automatic result_word_t smoothed_reading(input sample_word_t w);
		longint raw;
		longint t;
		longint fresh;
		longint ref_lo;
		longint ref_hi;
		longint raw_lo;
		longint raw_hi;
		logic [63:0] cal;
		bit matched;
		int c;
		result_word_t r;
		raw = longint'($signed(w.raw_temp));
		c = int'(w.channel);
		if (w.connected) begin
			t = raw;
			matched = 1'b1;
			cal = cfg_cal_a;
			if (w.device_address == cfg_known_a) begin
				cal = cfg_cal_a;
			end else if (w.device_address == cfg_known_b) begin
				cal = cfg_cal_b;
			end else begin
				matched = 1'b0;
			end
			if (matched) begin
				ref_lo = longint'($signed(cal[63:48]));
				ref_hi = longint'($signed(cal[47:32]));
				raw_lo = longint'($signed(cal[31:16]));
				raw_hi = longint'($signed(cal[15:0]));
				if (raw_hi == raw_lo) begin
					// zero raw range leaves the reading untouched
					n_zero_range++;
				end else begin
					n_calibrated++;
					t = ((raw - raw_lo) * (ref_hi - ref_lo)) / (raw_hi - raw_lo) + ref_lo;
					if (t > 32767 || t < -32768) begin
						n_saturated++;
						t = (t > 0) ? 64'sd32767 : -64'sd32768;
					end
				end
			end
			// 1/16 degree to 1/256 degree
			fresh = t * 16;
			if (avg_valid[c]) begin
				t = 9 * avg_value[c] + fresh;
				// divide by ten, halves away from zero
				avg_value[c] = (t >= 0) ? (t + 5) / 10 : -((5 - t) / 10);
			end else begin
				avg_value[c] = fresh;
			end
			avg_valid[c] = 1'b1;
		end else begin
			n_disconnected++;
			avg_valid[c] = 1'b0;
		end
		r.out_channel = w.channel;
		r.reading_valid = avg_valid[c];
		r.smoothed_temp = avg_valid[c] ? avg_value[c][23:0] : 24'sd0;
		return r;
	endfunction

	function automatic logic [63:0] any_address();
		case ($urandom_range(0, 4))
			0: return 64'd0;
			1: return ALL_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] any_calibration();
		logic [15:0] r;
		r = 16'($urandom);
		case ($urandom_range(0, 5))
			0: return CAL_RESET;
			1: return {$urandom, r, r};
			2: return SAT_CAL;
			3: return INV_CAL;
			4: return {16'($urandom_range(0, 160)) - 16'd80,
					16'd1520 + 16'($urandom_range(0, 160)),
					16'($urandom_range(0, 160)) - 16'd80,
					16'd1520 + 16'($urandom_range(0, 160))};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// setup and access phase write, then a read back of the same register
	task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("register %0d read back: expected %h, got %h", idx, value, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_KNOWN_A: cfg_known_a = value;
			REG_KNOWN_B: cfg_known_b = value;
			REG_CAL_A:   cfg_cal_a = value;
			REG_CAL_B:   cfg_cal_b = value;
			default: ;
		endcase
		write_count++;
	endtask

	// offers one sample word after a random gap and books its result once taken
	task automatic send_reading(input sample_word_t w, input result_word_t due);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample <= w;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		readings_due.push_back(due);
		sent_count++;
		@(negedge clk);
	endtask

	// drops valid and waits for every owed word, then a quiet tail
	task automatic settle(input int tail);
		sample_valid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// result side: hold the stall for a random gap once a word shows, then take it
	initial begin
		int gap;
		result_word_t due;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = steady_flow ? 0 : $urandom_range(0, 10);
			if (gap == 0) begin
				result_stall <= 1'b0;
				do @(posedge clk); while (!result_valid);
			end else begin
				result_stall <= 1'b1;
				do @(posedge clk); while (!result_valid);
				repeat (gap) @(negedge clk);
				result_stall <= 1'b0;
				@(posedge clk);
			end
			checked_count++;
			if (readings_due.size() == 0) begin
				$error("result word with no reading outstanding: %h", result);
				mismatches++;
			end else begin
				due = readings_due.pop_front();
				if (result.out_channel !== due.out_channel) begin
					$error("out_channel: expected %0d, got %0d",
						due.out_channel, result.out_channel);
					mismatches++;
				end
				if (result.reading_valid !== due.reading_valid) begin
					$error("reading_valid: expected %0d, got %0d",
						due.reading_valid, result.reading_valid);
					mismatches++;
				end
				if (result.smoothed_temp !== due.smoothed_temp) begin
					$error("smoothed_temp: expected %0d, got %0d",
						due.smoothed_temp, result.smoothed_temp);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	// main sequence: reset, directed rows, random phases, drain
	initial begin
		stim_row_t row;
		sample_word_t w;
		result_word_t due;
		logic [63:0] ka;
		logic [63:0] kb;
		int i;
		int phase;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				settle(4);
				write_register(row.reg_index, row.data);
			end else begin
				w.channel = row.channel;
				w.connected = row.connected;
				w.device_address = row.data;
				w.raw_temp = row.raw;
				due = smoothed_reading(w);
				if (row.typed) begin
					due.out_channel = row.channel;
					due.reading_valid = row.want_valid;
					due.smoothed_temp = row.want_temp;
				end
				send_reading(w, due);
			end
		end

		// each phase: drain, fresh settings, then a run of mostly connected readings
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle(4);
			steady_flow = (phase % 4 == 2);
			ka = any_address();
			// now and then both entries share an address, so priority is exercised
			kb = ($urandom_range(0, 5) == 0) ? ka : any_address();
			write_register(REG_KNOWN_A, ka);
			write_register(REG_KNOWN_B, kb);
			write_register(REG_CAL_A, any_calibration());
			write_register(REG_CAL_B, any_calibration());
			for (i = 0; i < PHASE_WORDS; i++) begin
				w.channel = 1'($urandom_range(0, 1));
				w.connected = ($urandom_range(0, 7) != 0);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: w.device_address = cfg_known_a;
					4, 5, 6:    w.device_address = cfg_known_b;
					7:          w.device_address = {$urandom, $urandom};
					8: w.device_address = cfg_known_a ^ (64'd1 << $urandom_range(0, 63));
					default: w.device_address = cfg_known_b ^ (64'd1 << $urandom_range(0, 63));
				endcase
				w.raw_temp = 12'($urandom);
				due = smoothed_reading(w);
				send_reading(w, due);
			end
		end
		steady_flow = 1'b0;

		// wait out the slowest calibrated word before closing
		settle(80);
		$display("%0d sample words sent, %0d result words checked, %0d register writes",
			sent_count, checked_count, write_count);
		$display("%0d calibrated (%0d saturated), %0d zero raw range, %0d disconnected",
			n_calibrated, n_saturated, n_zero_range, n_disconnected);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
